// ----- hw/rtl/tap_tempo_estimator_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Tap tempo estimator assertion macros
// Shared property shorthands for the tap tempo estimator RTL.
// ----------------------------------------------------------------------------
`ifndef TAP_TEMPO_ESTIMATOR_UNIT_ASSERT_SVH
`define TAP_TEMPO_ESTIMATOR_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define TTE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tap tempo estimator: same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define TTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tap tempo estimator: next-cycle check failed");

`endif

// ----- hw/rtl/tte_pkg.sv -----
// ----------------------------------------------------------------------------
// Tap tempo estimator package
// Defaults and constants shared by the tap tempo estimator RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package tte_pkg;

  localparam int MaxTapsDefault  = 8;
  localparam int TimeBitsDefault = 32;

  localparam int TapTimeWidth = 32;
  localparam int GapWidth     = 16;
  localparam int TempoWidth   = 24;
  localparam int HeldWidth    = 7;
  localparam int FracBits     = 8;
  localparam int ScaleWidth   = 16;

  // Beats per minute from a span in milliseconds: 60000 ms per minute.
  localparam logic [ScaleWidth-1:0] BpmScale = 16'd60000;
  localparam logic [TempoWidth-1:0] TempoMax = 24'hFFFFFF;
  localparam logic [GapWidth-1:0]   GapReset = 16'd2000;

endpackage

`default_nettype wire

// ----- hw/rtl/tap_tempo_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// Tap tempo estimator
// Mean tap interval over a window of recent taps, reported as BPM in Q.8.
// ----------------------------------------------------------------------------
// Each input transaction carries one tap timestamp in milliseconds. A tap that
// comes more than the configured gap after the previous stored tap empties
// the window first; the tap is then stored, keeping only the newest MAX_TAPS.
// The result is 60000 * (taps - 1) / (newest - oldest) with 8 fraction bits,
// truncated and saturated at 0xFFFFFF, flagged invalid with fewer than two
// taps or a non-positive span. A tap that yields a tempo passes the gap, read
// and span states and then the restoring divider to the result register,
// where NUM_W = 24 + clog2(MAX_TAPS) is the quotient width; the divider
// retires one quotient bit per cycle. A tap with no tempo skips the divider.
// s_tready is low while a tap is in work and rises the cycle after the result
// register loads, so no new tap is taken before the last result is loaded.
// A result waits in the output register while m_tready is low, and taps are still
// taken; a later result then waits in ST_DONE, and no new tap is taken meanwhile.
`default_nettype none

`include "tap_tempo_estimator_unit_assert.svh"

module tap_tempo_estimator_unit
  import tte_pkg::*;
#(
  parameter int MAX_TAPS  = MaxTapsDefault,
  parameter int TIME_BITS = TimeBitsDefault
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // Configuration: reset_gap_ms.
  input  wire logic                    cfg_wr_en,
  input  wire logic [GapWidth-1:0]     cfg_wr_data,
  // Input stream.
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [TapTimeWidth-1:0] s_tdata,   // [31:0] tap_time_ms
  // Output stream.
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [31:0]                  m_tdata,   // [23:0] tempo_q8, [30:24] taps_held
  output logic                         m_tuser    // [0] tempo_valid
);

  localparam int IDX_W  = $clog2(MAX_TAPS);
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int NUM_W  = ScaleWidth + IDX_W + FracBits;
  localparam int DCNT_W = $clog2(NUM_W + 1);
  localparam int SPAN_W = TIME_BITS - 1;
  localparam int PROD_W = NUM_W - FracBits;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_RD_OLD,
    ST_SPAN,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                  state;
  logic [GapWidth-1:0]     reset_gap;
  logic [IDX_W-1:0]        head;
  logic [CNT_W-1:0]        total;
  logic [TIME_BITS-1:0]    now;
  logic [TIME_BITS-1:0]    rd_data;
  logic [SPAN_W-1:0]       span;
  logic [SPAN_W-1:0]       rem;
  logic [NUM_W-1:0]        num;
  logic [DCNT_W-1:0]       div_cnt;
  logic [TempoWidth-1:0]   res_tempo;
  logic                    res_valid;

  logic [TIME_BITS-1:0]    ring [MAX_TAPS];

  logic [IDX_W-1:0]        prev_slot;
  logic [IDX_W-1:0]        old_slot;
  logic [IDX_W:0]          old_sum;
  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        head_next;
  logic [TIME_BITS-1:0]    sub_a;
  logic [TIME_BITS-1:0]    sub_b;
  logic [TIME_BITS:0]      sub_full;
  logic [TIME_BITS-1:0]    diff;
  logic                    borrow;
  logic                    gap_clear;
  logic [CNT_W-1:0]        base_total;
  logic [CNT_W-1:0]        total_next;
  logic [PROD_W-1:0]       prod;
  logic [TIME_BITS-1:0]    trial;
  logic                    accept;
  logic                    out_load;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // Ring slot arithmetic modulo MAX_TAPS.
  always_comb begin
    prev_slot = (head == '0) ? IDX_W'(MAX_TAPS - 1) : head - 1'b1;
    head_next = (head == IDX_W'(MAX_TAPS - 1)) ? '0 : head + 1'b1;
    old_sum   = {1'b0, head} + (IDX_W + 1)'(MAX_TAPS) - (IDX_W + 1)'(total);
    if (old_sum >= (IDX_W + 1)'(MAX_TAPS)) begin
      old_sum = old_sum - (IDX_W + 1)'(MAX_TAPS);
    end
    old_slot = old_sum[IDX_W-1:0];
    rd_addr  = (state == ST_IDLE) ? prev_slot : old_slot;
  end

  // One subtractor serves the gap, the span and the divider trial.
  always_comb begin
    trial      = {rem, num[NUM_W-1]};
    sub_a      = (state == ST_DIV) ? trial : now;
    sub_b      = (state == ST_DIV) ? {1'b0, span} : rd_data;
    sub_full   = {1'b0, sub_a} - {1'b0, sub_b};
    diff       = sub_full[TIME_BITS-1:0];
    borrow     = sub_full[TIME_BITS];
    gap_clear  = (total != '0) && !diff[TIME_BITS-1] &&
                 (diff > TIME_BITS'(reset_gap));
    base_total = gap_clear ? '0 : total;
    total_next = (base_total < CNT_W'(MAX_TAPS)) ? base_total + 1'b1 : base_total;
    prod       = PROD_W'(BpmScale) * PROD_W'(total - 1'b1);
  end

  // Timestamp store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (state == ST_GAP) begin
      ring[head] <= now;
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      reset_gap <= GapReset;
      head      <= '0;
      total     <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        reset_gap <= cfg_wr_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            now   <= TIME_BITS'(s_tdata);
            state <= ST_GAP;
          end
        end
        ST_GAP: begin
          head  <= head_next;
          total <= total_next;
          state <= ST_RD_OLD;
        end
        ST_RD_OLD: begin
          state <= ST_SPAN;
        end
        ST_SPAN: begin
          span    <= diff[SPAN_W-1:0];
          rem     <= '0;
          num     <= {prod, FracBits'(0)};
          div_cnt <= DCNT_W'(NUM_W);
          if (total < CNT_W'(2) || diff[TIME_BITS-1] || diff == '0) begin
            res_tempo <= '0;
            res_valid <= 1'b0;
            state     <= ST_DONE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Restoring division: the dividend shifts out of num as the
          // quotient shifts in.
          if (!borrow) begin
            rem <= diff[SPAN_W-1:0];
            num <= {num[NUM_W-2:0], 1'b1};
          end else begin
            rem <= trial[SPAN_W-1:0];
            num <= {num[NUM_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DCNT_W'(1)) begin
            state <= ST_DONE;
          end
          res_valid <= 1'b1;
        end
        ST_DONE: begin
          if (out_load) begin
            m_tuser  <= res_valid;
            if (res_valid) begin
              m_tdata[TempoWidth-1:0] <= (num > NUM_W'(TempoMax)) ?
                                         TempoMax : num[TempoWidth-1:0];
            end else begin
              m_tdata[TempoWidth-1:0] <= res_tempo;
            end
            m_tdata[TempoWidth+HeldWidth-1:TempoWidth] <= HeldWidth'(total);
            m_tdata[31] <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TTE_ASSERT_SAME(a_total_bounded, clk, rst, 1'b1, total <= CNT_W'(MAX_TAPS))
  `TTE_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, !s_tready)
  `TTE_ASSERT_SAME(a_invalid_is_zero, clk, rst, m_tvalid && !m_tuser,
                   m_tdata[TempoWidth-1:0] == '0)
  `TTE_ASSERT_SAME(a_held_in_range, clk, rst, m_tvalid,
                   m_tdata[TempoWidth+HeldWidth-1:TempoWidth] != '0 &&
                   m_tdata[TempoWidth+HeldWidth-1:TempoWidth] <= HeldWidth'(MAX_TAPS))

endmodule

`default_nettype wire

// ----- tb/tap_tempo_estimator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Tap tempo estimator testbench
// Streams tap timestamps into the estimator and checks every tempo result
// against a cycle-free model of the tap window. Directed taps cover the gap
// threshold, negative gaps, saturation, very long spans, counter wrap and a
// full window. Random tap trains then run under several gap settings with
// random sender bursts and receiver stall patterns.
// ----------------------------------------------------------------------------
module tap_tempo_estimator_unit_tb;
  import tte_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WindowTaps = 8;
  localparam int DrainCycles = 64;

  typedef struct packed {
    logic [TempoWidth-1:0] tempo;
    logic                  valid;
    logic [HeldWidth-1:0]  held;
  } tempo_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [GapWidth-1:0]     cfg_wr_data = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [TapTimeWidth-1:0] s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [31:0]             m_tdata;   // [23:0] tempo_q8, [30:24] taps_held
  logic                    m_tuser;   // [0] tempo_valid

  tap_tempo_estimator_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  always #5 clk = ~clk;

  // Model of the tap window.
  logic [TapTimeWidth-1:0] tap_hist [WindowTaps];
  logic [2:0]              hist_head = '0;
  logic [3:0]              hist_count = '0;
  logic [GapWidth-1:0]     gap_limit = GapReset;

  tempo_result_t pending_tempos [$];
  int            mismatches = 0;

  // Sender and receiver pacing.
  bit            sender_idles = 1'b0;
  int            burst_left = 0;
  logic [15:0]   ready_pattern = 16'hFFFF;
  logic [3:0]    ready_phase = '0;

  function automatic tempo_result_t predict_tempo(input logic [TapTimeWidth-1:0] now);
    logic [TapTimeWidth-1:0] delta;
    logic [2:0]              slot;
    logic [63:0]             num;
    logic [63:0]             quot;
    tempo_result_t           res;
    res = '0;
    if (hist_count != 0) begin
      slot = hist_head - 3'd1;
      delta = now - tap_hist[slot];
      // A negative gap never exceeds the threshold.
      if (!delta[TapTimeWidth-1] && delta > {16'd0, gap_limit}) begin
        hist_count = '0;
      end
    end
    tap_hist[hist_head] = now;
    hist_head = hist_head + 3'd1;
    if (hist_count < WindowTaps) begin
      hist_count = hist_count + 4'd1;
    end
    if (hist_count >= 2) begin
      // A full window wraps back onto the slot about to be overwritten.
      slot = hist_head - hist_count[2:0];
      delta = now - tap_hist[slot];
      if (!delta[TapTimeWidth-1] && delta != 0) begin
        num = 64'(BpmScale) * 64'(hist_count - 4'd1) * (64'd1 << FracBits);
        quot = num / 64'(delta);
        res.tempo = (quot > 64'(TempoMax)) ? TempoMax : quot[TempoWidth-1:0];
        res.valid = 1'b1;
      end
    end
    res.held = HeldWidth'(hist_count);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR: %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  always @(posedge clk) begin
    m_tready <= ready_pattern[ready_phase];
    ready_phase <= ready_phase + 4'd1;
  end

  always @(posedge clk) begin : check_results
    tempo_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_tempos.size() == 0) begin
        report_mismatch("result with no tap pending", m_tdata, 0);
      end else begin
        want = pending_tempos.pop_front();
        if (m_tdata[23:0] !== want.tempo) begin
          report_mismatch("tempo_q8", m_tdata[23:0], want.tempo);
        end
        if (m_tdata[30:24] !== want.held) begin
          report_mismatch("taps_held", m_tdata[30:24], want.held);
        end
        if (m_tdata[31] !== 1'b0) begin
          report_mismatch("tdata padding", m_tdata[31], 0);
        end
        if (m_tuser !== want.valid) begin
          report_mismatch("tempo_valid", m_tuser, want.valid);
        end
      end
    end
  end

  // Sends one tap; valid stays high afterwards so back-to-back taps need no toggle.
  task automatic send_tap(input logic [TapTimeWidth-1:0] tap_ms);
    int            idle_cycles;
    tempo_result_t expected;
    if (sender_idles && burst_left == 0) begin
      idle_cycles = $urandom_range(1, 40);
      s_tvalid <= 1'b0;
      repeat (idle_cycles) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata <= tap_ms;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected = predict_tempo(tap_ms);
    pending_tempos.insert(pending_tempos.size(), expected);
  endtask

  // Holds off the sender until every tap has produced its result.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_tempos.size() != 0) @(posedge clk);
  endtask

  task automatic write_gap_limit(input logic [GapWidth-1:0] limit_ms);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= limit_ms;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gap_limit = limit_ms;
  endtask

  task automatic set_pacing(input bit idles, input logic [15:0] pattern);
    sender_idles = idles;
    burst_left = 0;
    ready_pattern = pattern;
  endtask

  // Default threshold: a gap equal to it keeps the window, one more clears it.
  task automatic test_default_gap();
    send_tap(32'd1000);
    send_tap(32'd1000);
    send_tap(32'd3000);
    send_tap(32'd5001);
  endtask

  // An earlier tap is kept and gives a negative span.
  task automatic test_negative_gap();
    send_tap(32'd4900);
  endtask

  // Three taps over one millisecond overflow the tempo field.
  task automatic test_saturation();
    send_tap(32'd9000);
    send_tap(32'd9001);
    send_tap(32'd9001);
  endtask

  // Every step is a negative gap, yet newest minus oldest is a huge positive
  // span, so the quotient truncates to zero while the tempo stays valid.
  task automatic test_long_span();
    send_tap(32'h4000_0000);
    send_tap(32'h2000_0000);
    send_tap(32'hB000_0000);
  endtask

  task automatic test_counter_wrap();
    send_tap(32'hFFFF_FF00);
    send_tap(32'h0000_0100);
  endtask

  task automatic test_window_overflow();
    for (int k = 0; k < WindowTaps + 1; k++) begin
      send_tap(32'h0001_0000 + 32'(100 * k));
    end
  endtask

  // With a zero threshold only a repeated or earlier timestamp keeps the window.
  task automatic test_zero_gap_limit();
    drain_results();
    write_gap_limit('0);
    send_tap(32'h0002_0000);
    send_tap(32'h0002_0000);
    send_tap(32'h0002_0001);
  endtask

  // Tap trains with random content: mostly taps within the threshold, with
  // long pauses, small backward jitter and wild timestamps mixed in.
  task automatic test_random_trains(input logic [GapWidth-1:0] limit_ms, input int taps,
                                    input bit idles, input logic [15:0] pattern);
    logic [TapTimeWidth-1:0] now_ms;
    int                      pick;
    drain_results();
    write_gap_limit(limit_ms);
    set_pacing(idles, pattern);
    now_ms = $urandom;
    for (int k = 0; k < taps; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        now_ms = now_ms + $urandom_range(0, limit_ms);
      end else if (pick < 92) begin
        now_ms = now_ms + limit_ms + $urandom_range(1, 100);
      end else if (pick < 97) begin
        now_ms = now_ms - $urandom_range(1, 50);
      end else begin
        now_ms = $urandom;
      end
      send_tap(now_ms);
    end
  endtask

  initial begin
    hist_head = '0;
    hist_count = '0;
    gap_limit = GapReset;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_pacing(1'b1, 16'($urandom) | 16'h0001);
    test_default_gap();
    test_negative_gap();
    test_saturation();
    test_long_span();
    test_counter_wrap();
    test_window_overflow();
    test_zero_gap_limit();

    test_random_trains(16'hFFFF, 110, 1'b1, 16'($urandom) | 16'h0001);
    test_random_trains(16'd1, 110, 1'b0, 16'hFFFF);
    test_random_trains(16'($urandom_range(1, 65535)), 110, 1'b1, 16'($urandom) | 16'h0001);
    test_random_trains(16'd300, 110, 1'b1, 16'hFFFF);
    test_random_trains(GapReset, 110, 1'b0, 16'($urandom) | 16'h0001);

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (pending_tempos.size() != 0) begin
      report_mismatch("taps left without a result", pending_tempos.size(), 0);
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- tap_tempo_estimator_unit.f -----
+incdir+hw/rtl
hw/rtl/tte_pkg.sv
hw/rtl/tap_tempo_estimator_unit.sv
tb/tap_tempo_estimator_unit_tb.sv
